@@ sv/ctp_pkg.sv @@
// Package for the comb table packer: request structs, op and result codes,
// controller state type and default sizes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

    localparam int TABLE_DEPTH_DEF   = 4096;
    localparam int ALPHABET_SIZE_DEF = 256;
    localparam int MAX_STATES_DEF    = 1024;

    localparam logic [1:0] OP_TRANS = 2'd0;
    localparam logic [1:0] OP_EMPTY = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] KIND_PLACED   = 2'd0;
    localparam logic [1:0] KIND_READ     = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  symbol;
        logic [9:0]  target_state;
        logic        last;
        logic [11:0] index;
    } t_in_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  state_index;
        logic [11:0] base;
        logic [9:0]  entry_next;
        logic        entry_used;
        logic [10:0] entry_owner;
        logic [12:0] table_len;
    } t_out_req;

    // One pending transition of the row being collected.
    typedef struct packed {
        logic [7:0] sym;
        logic [9:0] tgt;
    } t_row_entry;

    // One packed table slot; an owner of zero marks the slot empty.
    typedef struct packed {
        logic [9:0]  next;
        logic [10:0] owner;
    } t_slot;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDOUT,
        S_FIT_START,
        S_FIT_OWN,
        S_FIT_CHK,
        S_DECIDE,
        S_PLACE_WR,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ sv/ctp_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. Standalone, no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module ctp_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 18
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/comb_table_packer_core.sv @@
// Comb table packer top level: controller, row buffer RAM and slot RAM.
// Depends on ctp_pkg and ctp_ram.
// A read request passes through S_RDOUT and S_EMIT before its result is
// registered at the output. A marked transition runs a first-fit search over
// the slot RAM, probing the row's symbols at each candidate base, then writes
// the row and emits its result. Requests are taken one at a time.
// Reset: synchronous, active low; a clearing pass then empties the slot RAM
// one slot at a time, and no request is accepted until it is done.
`timescale 1ns / 1ps
`default_nettype none

module comb_table_packer_core #(
    parameter int TABLE_DEPTH   = ctp_pkg::TABLE_DEPTH_DEF,
    parameter int ALPHABET_SIZE = ctp_pkg::ALPHABET_SIZE_DEF,
    parameter int MAX_STATES    = ctp_pkg::MAX_STATES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire ctp_pkg::t_in_req i_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output ctp_pkg::t_out_req     o_out
);

    // Slot address, base/length, row index, row count and state widths.
    localparam int AW   = $clog2(TABLE_DEPTH);
    localparam int LW   = $clog2(TABLE_DEPTH + 1);
    localparam int SUMW = LW + 1;
    localparam int RW   = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int CW   = $clog2(ALPHABET_SIZE + 1);
    localparam int SW   = $clog2(MAX_STATES);
    localparam int ROWW = $bits(ctp_pkg::t_row_entry);
    localparam int SLTW = $bits(ctp_pkg::t_slot);

    ctp_pkg::t_state   r_state, n_state;
    logic [AW-1:0]     r_clr, n_clr;
    logic [CW-1:0]     r_count, n_count;
    logic [7:0]        r_min, n_min;
    logic [7:0]        r_max, n_max;
    logic [LW-1:0]     r_used, n_used;
    logic [SW-1:0]     r_st, n_st;
    logic [LW-1:0]     r_base, n_base;
    logic [RW-1:0]     r_k, n_k;
    logic              r_in_range, n_in_range;
    ctp_pkg::t_out_req r_res, n_res;
    logic              r_out_valid, n_out_valid;
    ctp_pkg::t_out_req r_out, n_out;

    logic                 row_we, row_re;
    logic [RW-1:0]        row_waddr, row_raddr;
    ctp_pkg::t_row_entry  row_wdata, row_rdata;
    logic [ROWW-1:0]      row_rdata_raw;
    logic                 slot_we, slot_re;
    logic [AW-1:0]        slot_waddr, slot_raddr;
    ctp_pkg::t_slot       slot_wdata, slot_rdata;
    logic [SLTW-1:0]      slot_rdata_raw;

    logic                 in_acc;
    logic                 add_pair;
    logic                 k_last;
    logic [SUMW-1:0]      slot_sum;
    logic [SUMW-1:0]      min_sum;
    logic [SUMW-1:0]      max_sum;
    logic [SW-1:0]        st_inc;
    logic [10:0]          owner_val;

    // Row buffer: pending (symbol, target) pairs of the state being collected.
    ctp_ram #(
        .DEPTH (ALPHABET_SIZE),
        .AW    (RW),
        .DW    (ROWW)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_re    (row_re),
        .i_raddr (row_raddr),
        .o_rdata (row_rdata_raw)
    );

    // Packed table: next state and owner of every slot.
    ctp_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW),
        .DW    (SLTW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_re    (slot_re),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata_raw)
    );

    assign row_rdata  = ctp_pkg::t_row_entry'(row_rdata_raw);
    assign slot_rdata = ctp_pkg::t_slot'(slot_rdata_raw);

    // Requests are taken only while the controller is idle; the output
    // register lets the next request in while a result still waits.
    assign in_acc      = i_in_valid && (r_state == ctp_pkg::S_IDLE);
    assign o_in_stall  = (r_state != ctp_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A pair is stored only if its symbol is in the alphabet and the row
    // buffer still has room.
    assign add_pair = (32'(i_in.symbol) < ALPHABET_SIZE) && (32'(r_count) < ALPHABET_SIZE);

    assign k_last    = ((CW'(r_k) + CW'(1)) == r_count);
    assign slot_sum  = SUMW'(r_base) + SUMW'(row_rdata.sym);
    assign min_sum   = SUMW'(r_base) + SUMW'(r_min);
    assign max_sum   = SUMW'(r_base) + SUMW'(r_max);
    assign st_inc    = (r_st == SW'(MAX_STATES - 1)) ? '0 : r_st + SW'(1);
    assign owner_val = 11'(32'(r_st) + 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ctp_pkg::S_CLEAR;
            r_clr       <= '0;
            r_count     <= '0;
            r_min       <= 8'd255;
            r_max       <= '0;
            r_used      <= '0;
            r_st        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_count     <= n_count;
            r_min       <= n_min;
            r_max       <= n_max;
            r_used      <= n_used;
            r_st        <= n_st;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base     <= n_base;
        r_k        <= n_k;
        r_in_range <= n_in_range;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_count     = r_count;
        n_min       = r_min;
        n_max       = r_max;
        n_used      = r_used;
        n_st        = r_st;
        n_base      = r_base;
        n_k         = r_k;
        n_in_range  = r_in_range;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        row_we     = 1'b0;
        row_waddr  = r_count[RW-1:0];
        row_wdata  = '{sym: i_in.symbol, tgt: i_in.target_state};
        row_re     = 1'b0;
        row_raddr  = '0;
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        slot_re    = 1'b0;
        slot_raddr = '0;

        // The downstream side takes the held result.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ctp_pkg::S_CLEAR: begin
                // Clearing pass: empty one slot per cycle after reset.
                slot_we    = 1'b1;
                slot_waddr = r_clr;
                n_clr      = r_clr + AW'(1);
                if (r_clr == AW'(TABLE_DEPTH - 1)) begin
                    n_state = ctp_pkg::S_IDLE;
                end
            end

            ctp_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (i_in.op)
                        ctp_pkg::OP_READ: begin
                            slot_re    = 1'b1;
                            slot_raddr = AW'(i_in.index);
                            n_in_range = (32'(i_in.index) < TABLE_DEPTH);
                            n_state    = ctp_pkg::S_RDOUT;
                        end
                        ctp_pkg::OP_EMPTY: begin
                            // A state without transitions drops pending pairs.
                            n_res             = '0;
                            n_res.kind        = ctp_pkg::KIND_PLACED;
                            n_res.state_index = 10'(r_st);
                            n_count           = '0;
                            n_min             = 8'd255;
                            n_max             = '0;
                            n_st              = st_inc;
                            n_state           = ctp_pkg::S_EMIT;
                        end
                        ctp_pkg::OP_TRANS: begin
                            if (add_pair) begin
                                row_we  = 1'b1;
                                n_count = r_count + CW'(1);
                                if (i_in.symbol < r_min) begin
                                    n_min = i_in.symbol;
                                end
                                if (i_in.symbol > r_max) begin
                                    n_max = i_in.symbol;
                                end
                            end
                            if (i_in.last) begin
                                if (!add_pair && (r_count == '0)) begin
                                    n_res             = '0;
                                    n_res.kind        = ctp_pkg::KIND_PLACED;
                                    n_res.state_index = 10'(r_st);
                                    n_min             = 8'd255;
                                    n_max             = '0;
                                    n_st              = st_inc;
                                    n_state           = ctp_pkg::S_EMIT;
                                end else begin
                                    n_base  = '0;
                                    n_state = ctp_pkg::S_FIT_START;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ctp_pkg::S_RDOUT: begin
                n_res      = '0;
                n_res.kind = ctp_pkg::KIND_READ;
                if (r_in_range && (slot_rdata.owner != '0)) begin
                    n_res.entry_next  = slot_rdata.next;
                    n_res.entry_used  = 1'b1;
                    n_res.entry_owner = slot_rdata.owner;
                end
                n_state = ctp_pkg::S_EMIT;
            end

            ctp_pkg::S_FIT_START: begin
                // Once the lowest symbol lands at or past the used length,
                // every slot of the row is free at this base.
                if (min_sum >= SUMW'(r_used)) begin
                    n_state = ctp_pkg::S_DECIDE;
                end else begin
                    n_k       = '0;
                    row_re    = 1'b1;
                    row_raddr = '0;
                    n_state   = ctp_pkg::S_FIT_OWN;
                end
            end

            ctp_pkg::S_FIT_OWN: begin
                // Row entry is back; look up the slot it would occupy.
                n_in_range = (slot_sum < SUMW'(r_used));
                slot_re    = 1'b1;
                slot_raddr = slot_sum[AW-1:0];
                n_state    = ctp_pkg::S_FIT_CHK;
            end

            ctp_pkg::S_FIT_CHK: begin
                if (r_in_range && (slot_rdata.owner != '0)) begin
                    n_base  = r_base + LW'(1);
                    n_state = ctp_pkg::S_FIT_START;
                end else if (k_last) begin
                    n_state = ctp_pkg::S_DECIDE;
                end else begin
                    n_k       = r_k + RW'(1);
                    row_re    = 1'b1;
                    row_raddr = r_k + RW'(1);
                    n_state   = ctp_pkg::S_FIT_OWN;
                end
            end

            ctp_pkg::S_DECIDE: begin
                if (max_sum >= SUMW'(TABLE_DEPTH)) begin
                    // Overflow: nothing is written, the state number is spent.
                    n_res             = '0;
                    n_res.kind        = ctp_pkg::KIND_OVERFLOW;
                    n_res.state_index = 10'(r_st);
                    n_res.base        = 12'(r_base);
                    n_count           = '0;
                    n_min             = 8'd255;
                    n_max             = '0;
                    n_st              = st_inc;
                    n_state           = ctp_pkg::S_EMIT;
                end else begin
                    n_k       = '0;
                    row_re    = 1'b1;
                    row_raddr = '0;
                    n_state   = ctp_pkg::S_PLACE_WR;
                end
            end

            ctp_pkg::S_PLACE_WR: begin
                // Write pairs in arrival order so a repeated symbol keeps
                // the later target.
                slot_we    = 1'b1;
                slot_waddr = slot_sum[AW-1:0];
                slot_wdata = '{next: row_rdata.tgt, owner: owner_val};
                if (k_last) begin
                    if ((max_sum + SUMW'(1)) > SUMW'(r_used)) begin
                        n_used = LW'(max_sum + SUMW'(1));
                    end
                    n_res             = '0;
                    n_res.kind        = ctp_pkg::KIND_PLACED;
                    n_res.state_index = 10'(r_st);
                    n_res.base        = 12'(r_base);
                    n_count           = '0;
                    n_min             = 8'd255;
                    n_max             = '0;
                    n_st              = st_inc;
                    n_state           = ctp_pkg::S_EMIT;
                end else begin
                    n_k       = r_k + RW'(1);
                    row_re    = 1'b1;
                    row_raddr = r_k + RW'(1);
                end
            end

            ctp_pkg::S_EMIT: begin
                // Hand the result to the output register once it is free.
                if (!r_out_valid || !i_out_stall) begin
                    n_out           = r_res;
                    n_out.table_len = 13'(r_used);
                    n_out_valid     = 1'b1;
                    n_state         = ctp_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = ctp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ test/ctp_checker.sv @@
// Checker for the comb table packer: watches both request channels, predicts
// each result from its own copy of the packing state, and compares in order.
// Depends on ctp_pkg for the request structs and op and result codes.
`timescale 1ns / 1ps

module ctp_checker (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  ctp_pkg::t_in_req  i_in,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  ctp_pkg::t_out_req i_out,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_placed,
    output int                o_reads,
    output int                o_overflows
);

    localparam int DEPTH = ctp_pkg::TABLE_DEPTH_DEF;
    localparam int ALPHA = ctp_pkg::ALPHABET_SIZE_DEF;

    // Row being collected, in arrival order.
    logic [7:0]  row_sym [ALPHA];
    logic [9:0]  row_tgt [ALPHA];
    int          row_len;
    int          row_lo;
    int          row_hi;

    // Packed table and its bookkeeping.
    logic [9:0]  next_mem  [DEPTH];
    logic [10:0] owner_mem [DEPTH];
    int          used_len;
    logic [9:0]  st_count;

    ctp_pkg::t_out_req placement_q [$];

    assign o_pending = placement_q.size();

    function automatic bit slot_busy(int slot);
        return slot < used_len && slot < DEPTH && owner_mem[slot] != 0;
    endfunction

    function automatic bit row_fits(int b);
        for (int k = 0; k < row_len; k++) begin
            if (slot_busy(b + row_sym[k])) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_row();
        row_len = 0;
        row_lo  = ALPHA - 1;
        row_hi  = 0;
    endtask

    task automatic predict_request(input ctp_pkg::t_in_req r);
        ctp_pkg::t_out_req res;
        bit                has_res;
        int                b;
        res     = '0;
        has_res = 1'b0;
        case (r.op)
            ctp_pkg::OP_READ: begin
                res.kind = ctp_pkg::KIND_READ;
                if (owner_mem[r.index] != 0) begin
                    res.entry_next  = next_mem[r.index];
                    res.entry_used  = 1'b1;
                    res.entry_owner = owner_mem[r.index];
                end
                has_res = 1'b1;
            end
            ctp_pkg::OP_EMPTY: begin
                clear_row();
                res.kind        = ctp_pkg::KIND_PLACED;
                res.state_index = st_count;
                st_count        = st_count + 1'b1;
                has_res         = 1'b1;
            end
            ctp_pkg::OP_TRANS: begin
                if (row_len < ALPHA) begin
                    row_sym[row_len] = r.symbol;
                    row_tgt[row_len] = r.target_state;
                    row_len++;
                    if (r.symbol < row_lo) row_lo = r.symbol;
                    if (r.symbol > row_hi) row_hi = r.symbol;
                end
                if (r.last) begin
                    res.kind        = ctp_pkg::KIND_PLACED;
                    res.state_index = st_count;
                    if (row_len != 0) begin
                        // First fit: lowest base whose slots are all free or
                        // lie past the used length.
                        b = 0;
                        while (b + row_lo < used_len) begin
                            if (!slot_busy(b + row_lo) && row_fits(b)) break;
                            b++;
                        end
                        res.base = b[11:0];
                        if (b + row_hi >= DEPTH) begin
                            res.kind = ctp_pkg::KIND_OVERFLOW;
                        end else begin
                            // Later pairs overwrite earlier ones on a repeat.
                            for (int k = 0; k < row_len; k++) begin
                                next_mem[b + row_sym[k]]  = row_tgt[k];
                                owner_mem[b + row_sym[k]] = {1'b0, st_count} + 11'd1;
                            end
                            if (b + row_hi + 1 > used_len) used_len = b + row_hi + 1;
                        end
                    end
                    clear_row();
                    st_count = st_count + 1'b1;
                    has_res  = 1'b1;
                end
            end
            default: ;
        endcase
        res.table_len = used_len[12:0];
        if (has_res) placement_q.push_back(res);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        ctp_pkg::t_out_req e;
        if (!i_rst_n) begin
            for (int s = 0; s < DEPTH; s++) owner_mem[s] = '0;
            clear_row();
            used_len     = 0;
            st_count     = '0;
            placement_q.delete();
            o_fail_count = 0;
            o_placed     = 0;
            o_reads      = 0;
            o_overflows  = 0;
        end else begin
            // Results are compared before this edge's request is modeled;
            // a request never produces its result at its own acceptance edge.
            if (i_out_valid && !i_out_stall) begin
                if (placement_q.size() == 0) begin
                    $error("result with no expected result pending");
                    o_fail_count++;
                end else begin
                    e = placement_q.pop_front();
                    check_field("kind", e.kind, i_out.kind);
                    check_field("state_index", e.state_index, i_out.state_index);
                    check_field("base", e.base, i_out.base);
                    check_field("entry_next", e.entry_next, i_out.entry_next);
                    check_field("entry_used", e.entry_used, i_out.entry_used);
                    check_field("entry_owner", e.entry_owner, i_out.entry_owner);
                    check_field("table_len", e.table_len, i_out.table_len);
                    case (e.kind)
                        ctp_pkg::KIND_READ:     o_reads++;
                        ctp_pkg::KIND_OVERFLOW: o_overflows++;
                        default:                o_placed++;
                    endcase
                end
            end
            if (i_in_valid && !i_in_stall) predict_request(i_in);
        end
    end

    initial begin
        o_fail_count = 0;
        o_placed     = 0;
        o_reads      = 0;
        o_overflows  = 0;
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top for comb_table_packer_core: clock, reset, request stimulus,
// result-side stalls and the final verdict. Depends on ctp_pkg and ctp_checker.
`timescale 1ns / 1ps

module tb_top;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              in_valid   = 1'b0;
    ctp_pkg::t_in_req  in_req     = '0;
    logic              out_stall  = 1'b0;
    logic              in_stall;
    logic              out_valid;
    ctp_pkg::t_out_req out_req;

    int       fail_count;
    int       pending;
    int       n_placed;
    int       n_reads;
    int       n_overflows;

    // Knobs shared between the request driver and the result-side staller.
    bit       idle_on   = 1'b0;
    bit       stall_on  = 1'b0;
    bit       hold_req  = 1'b0;
    bit       hold_done = 1'b0;
    int       sent      = 0;

    always #10 i_clk = ~i_clk;

    comb_table_packer_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_req)
    );

    ctp_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_req),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_req),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_placed     (n_placed),
        .o_reads      (n_reads),
        .o_overflows  (n_overflows)
    );

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return 0;
        if (p < 88) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A transition request with every other field random; callers then fix what matters.
    function automatic ctp_pkg::t_in_req any_req();
        ctp_pkg::t_in_req r;
        r.op           = ctp_pkg::OP_TRANS;
        r.symbol       = 8'($urandom);
        r.target_state = 10'($urandom);
        r.last         = 1'($urandom);
        r.index        = 12'($urandom);
        return r;
    endfunction

    // Offers one request and holds it until the block takes it. The payload
    // stays put while stalled.
    task automatic send(input ctp_pkg::t_in_req r);
        int gap;
        in_valid <= 1'b1;
        in_req   <= r;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (r.op != ctp_pkg::OP_NOP) sent++;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_op(input logic [1:0] op, input logic [7:0] sym,
                           input logic [9:0] tgt, input logic last,
                           input logic [11:0] idx);
        ctp_pkg::t_in_req r;
        r.op           = op;
        r.symbol       = sym;
        r.target_state = tgt;
        r.last         = last;
        r.index        = idx;
        send(r);
    endtask

    task automatic send_read(input logic [11:0] idx);
        ctp_pkg::t_in_req r;
        r       = any_req();
        r.op    = ctp_pkg::OP_READ;
        r.index = idx;
        send(r);
    endtask

    // One state's transitions with random content. Symbols either spread over
    // the whole alphabet or huddle in a narrow window, which packs densely.
    // A broken row ends in an empty-state request that throws the pairs away.
    task automatic send_row(input int n, input bit broken);
        ctp_pkg::t_in_req r;
        int               lo;
        bit               narrow;
        lo     = $urandom_range(0, 255);
        narrow = $urandom_range(0, 1);
        for (int k = 0; k < n; k++) begin
            r        = any_req();
            r.op     = ctp_pkg::OP_TRANS;
            r.last   = (k == n - 1) && !broken;
            if (narrow) r.symbol = 8'((lo + $urandom_range(0, 15)) > 255 ?
                                      255 : lo + $urandom_range(0, 15));
            send(r);
            if ($urandom_range(0, 9) == 0) send_read(12'($urandom_range(0, 1023)));
        end
        if (broken) begin
            r    = any_req();
            r.op = ctp_pkg::OP_EMPTY;
            send(r);
        end
    endtask

    // Result-side stalls. A long hold-off is taken once on request so that
    // the block backs up and stalls its own input.
    initial begin : stall_gen
        int n;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                out_stall <= 1'b0;
                hold_done <= 1'b1;
            end else if (stall_on && $urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                n = pick_gap() + 1;
                repeat (n) @(posedge i_clk);
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Hard stop in case the block hangs.
    initial begin
        #(400_000_000);
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        ctp_pkg::t_in_req r;
        int               p;
        int               n_row;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, without idling: reads of an empty table, an empty
        // state, a row touching both symbol extremes with a repeated symbol
        // (the later pair must win), a discarded partial row, an ignored op,
        // and reads of what was written.
        send_read(12'd0);
        send_read(12'd4095);
        send_op(ctp_pkg::OP_EMPTY, 8'd0, 10'd0, 1'b0, 12'd0);
        send_op(ctp_pkg::OP_TRANS, 8'd0, 10'd0, 1'b0, 12'hFFF);
        send_op(ctp_pkg::OP_TRANS, 8'd255, 10'd1023, 1'b0, 12'd0);
        send_op(ctp_pkg::OP_TRANS, 8'd0, 10'd5, 1'b1, 12'd0);
        send_read(12'd0);
        send_read(12'd255);
        send_op(ctp_pkg::OP_TRANS, 8'd7, 10'd3, 1'b0, 12'd0);
        send_op(ctp_pkg::OP_EMPTY, 8'hFF, 10'h3FF, 1'b1, 12'hFFF);
        send_op(ctp_pkg::OP_NOP, 8'hAA, 10'h155, 1'b1, 12'hAAA);
        send_op(ctp_pkg::OP_TRANS, 8'd128, 10'd512, 1'b1, 12'd0);
        send_op(ctp_pkg::OP_TRANS, 8'd1, 10'h155, 1'b0, 12'h555);
        send_op(ctp_pkg::OP_TRANS, 8'd254, 10'h2AA, 1'b1, 12'hAAA);
        send_read(12'd128);
        send_read(12'd1);
        send_read(12'd256);
        send_read(12'd7);

        // Random part: mostly well-formed rows, with empty states, reads,
        // broken rows and ignored ops mixed in.
        idle_on  = 1'b1;
        stall_on = 1'b1;
        while (sent < 950) begin
            if (sent > 350 && !hold_req) hold_req <= 1'b1;
            if (sent > 750) begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end
            p = $urandom_range(0, 99);
            if (p < 50) begin
                n_row = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12)
                                                    : $urandom_range(1, 5);
                send_row(n_row, $urandom_range(0, 15) == 0);
            end else if (p < 72) begin
                r    = any_req();
                r.op = ctp_pkg::OP_EMPTY;
                send(r);
            end else if (p < 95) begin
                send_read(($urandom_range(0, 3) == 0) ? 12'($urandom)
                                                      : 12'($urandom_range(0, 1500)));
            end else begin
                r    = any_req();
                r.op = ctp_pkg::OP_NOP;
                send(r);
            end
        end
        if (!hold_done) begin
            in_valid <= 1'b0;
            while (!hold_done) @(posedge i_clk);
        end

        // A run of empty states with idling and stalls back on.
        idle_on  = 1'b1;
        stall_on = 1'b1;
        for (int k = 0; k < 430; k++) begin
            r    = any_req();
            r.op = ctp_pkg::OP_EMPTY;
            send(r);
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);

        $display("Run sent %0d requests: %0d states placed, %0d slot reads,",
                 sent, n_placed, n_reads);
        $display("and %0d overflow rejections.", n_overflows);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
